// ----- rtl/address_window_translator_core_assert.svh -----
// Assertion macros for the translator RTL.
// Both sample on clk and are muted while rst is high.
`ifndef ADDRESS_WINDOW_TRANSLATOR_CORE_ASSERT_SVH
`define ADDRESS_WINDOW_TRANSLATOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define AWT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("translator assertion failed");

// Next-cycle implication.
`define AWT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("translator assertion failed");

`endif

// ----- rtl/awt_pkg.sv -----
package awt_pkg;

  localparam int MAX_WINDOWS = 16;
  localparam int ADDR_W      = 32;
  localparam int SLOT_W      = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_FWD   = 2'd1,
    OP_REV   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    BY_NONE  = 2'd0,
    BY_DRAM  = 2'd1,
    BY_TABLE = 2'd2
  } by_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DRAM_VBASE = 2'd0,
    CFG_DRAM_PBASE = 2'd1,
    CFG_DRAM_SIZE  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_SEL,
    ST_OUT
  } back_state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] vbase;
    logic [ADDR_W-1:0] pbase;
    logic [ADDR_W-1:0] size;
  } dram_cfg_t;

  // One classified transaction as queued between front and back.
  typedef struct packed {
    op_t               op;
    logic              idx_ok;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] vbase;
    logic [ADDR_W-1:0] pbase;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] lookup;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  // Range test at ADDR_W+1 bits: addr >= base and addr - base < size.
  function automatic logic window_hit(input logic [ADDR_W-1:0] base,
                                      input logic [ADDR_W-1:0] size,
                                      input logic [ADDR_W-1:0] addr);
    logic [ADDR_W:0] diff;
    diff = {1'b0, addr} - {1'b0, base};
    return !diff[ADDR_W] && (diff[ADDR_W-1:0] < size);
  endfunction

endpackage

// ----- rtl/awt_in_if.sv -----
interface awt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [3:0]  entry_index;
  logic [31:0] entry_virtual_base;
  logic [31:0] entry_physical_base;
  logic [31:0] entry_size;
  logic [31:0] lookup_address;

  modport source (
    output valid, op, entry_index, entry_virtual_base, entry_physical_base,
           entry_size, lookup_address,
    input  ready
  );

  modport sink (
    input  valid, op, entry_index, entry_virtual_base, entry_physical_base,
           entry_size, lookup_address,
    output ready
  );
endinterface

// ----- rtl/awt_out_if.sv -----
interface awt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_address;
  logic [1:0]  matched_by;
  logic        fault;
  logic [3:0]  matched_slot;

  modport source (
    output valid, result_address, matched_by, fault, matched_slot,
    input  ready
  );

  modport sink (
    input  valid, result_address, matched_by, fault, matched_slot,
    output ready
  );
endinterface

// ----- rtl/awt_front.sv -----
module awt_front import awt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  awt_in_if.sink            request,
  input  logic              pop,
  output q_head_t           head,
  output logic [QCNT_W-1:0] fill
);

  item_t             q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  item_t             item_in;

  assign request.ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign push          = request.valid && request.ready;

  // classify
  always_comb begin
    item_in.op     = op_t'(request.op);
    item_in.idx_ok = (32'(request.entry_index) < 32'(MAX_WINDOWS));
    item_in.slot   = SLOT_W'(request.entry_index);
    item_in.vbase  = ADDR_W'(request.entry_virtual_base);
    item_in.pbase  = ADDR_W'(request.entry_physical_base);
    item_in.size   = ADDR_W'(request.entry_size);
    item_in.lookup = ADDR_W'(request.lookup_address);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head.valid = (count != '0);
  assign head.item  = q_mem[rd_ptr];
  assign fill       = count;

endmodule

// ----- rtl/awt_back.sv -----
module awt_back import awt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  dram_cfg_t dram,
  input  q_head_t   head,
  output logic      pop,
  awt_out_if.source response
);

  back_state_t state, state_next;
  item_t       cur;
  logic        cur_load;

  logic [ADDR_W-1:0] tbl_vbase [MAX_WINDOWS];
  logic [ADDR_W-1:0] tbl_pbase [MAX_WINDOWS];
  logic [ADDR_W-1:0] tbl_size  [MAX_WINDOWS];
  logic              tbl_we;

  logic [MAX_WINDOWS-1:0] hit_vec, hits;
  logic                   dram_hit_c, dram_hit;
  logic [SLOT_W-1:0]      sel_c, sel;
  logic                   hit_any;
  logic [ADDR_W-1:0]      offset_c, offset;

  logic [ADDR_W-1:0] res_c, res;
  by_t               by_c, by;
  logic              flt_c, flt;
  logic [SLOT_W-1:0] slot_c, slot;
  logic              out_valid, out_free, out_load;

  assign out_free = !out_valid || response.ready;

  // compare stage: one range check per slot, plus the DRAM window
  always_comb begin
    for (int i = 0; i < MAX_WINDOWS; i++) begin
      hit_vec[i] = window_hit((cur.op == OP_REV) ? tbl_pbase[i] : tbl_vbase[i],
                              tbl_size[i], cur.lookup);
    end
    dram_hit_c = (cur.op == OP_FWD) && window_hit(dram.vbase, dram.size, cur.lookup);
  end

  // select stage: lowest matching slot wins
  always_comb begin
    sel_c = '0;
    for (int i = MAX_WINDOWS - 1; i >= 0; i--) begin
      if (hits[i]) begin
        sel_c = SLOT_W'(i);
      end
    end
    if (dram_hit) begin
      offset_c = cur.lookup - dram.vbase;
    end else if (cur.op == OP_REV) begin
      offset_c = cur.lookup - tbl_pbase[sel_c];
    end else begin
      offset_c = cur.lookup - tbl_vbase[sel_c];
    end
  end

  // result stage
  always_comb begin
    res_c  = '0;
    by_c   = BY_NONE;
    flt_c  = 1'b0;
    slot_c = '0;
    unique case (cur.op)
      OP_FWD: begin
        if (dram_hit) begin
          res_c = dram.pbase + offset;
          by_c  = BY_DRAM;
        end else if (hit_any) begin
          res_c  = tbl_pbase[sel] + offset;
          by_c   = BY_TABLE;
          slot_c = sel;
        end else begin
          flt_c = 1'b1;
        end
      end
      OP_REV: begin
        if (hit_any) begin
          res_c  = tbl_vbase[sel] + offset;
          by_c   = BY_TABLE;
          slot_c = sel;
        end else begin
          flt_c = 1'b1;
        end
      end
      OP_WRITE, OP_NONE: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    cur_load   = 1'b0;
    tbl_we     = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (head.valid) begin
          pop        = 1'b1;
          cur_load   = 1'b1;
          state_next = ST_CMP;
        end
      end
      ST_CMP: state_next = ST_SEL;
      ST_SEL: state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          tbl_we   = (cur.op == OP_WRITE) && cur.idx_ok;
          if (head.valid) begin
            pop        = 1'b1;
            cur_load   = 1'b1;
            state_next = ST_CMP;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (response.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // sizes reset to zero so every slot starts empty
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_WINDOWS; i++) begin
        tbl_size[i] <= '0;
      end
    end else if (tbl_we) begin
      tbl_size[cur.slot] <= cur.size;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_vbase[cur.slot] <= cur.vbase;
      tbl_pbase[cur.slot] <= cur.pbase;
    end
    if (cur_load) begin
      cur <= head.item;
    end
    if (state == ST_CMP) begin
      hits     <= hit_vec;
      dram_hit <= dram_hit_c;
    end
    if (state == ST_SEL) begin
      sel     <= sel_c;
      offset  <= offset_c;
      hit_any <= |hits;
    end
    if (out_load) begin
      res  <= res_c;
      by   <= by_c;
      flt  <= flt_c;
      slot <= slot_c;
    end
  end

  assign response.valid          = out_valid;
  assign response.result_address = 32'(res);
  assign response.matched_by     = 2'(by);
  assign response.fault          = flt;
  assign response.matched_slot   = 4'(slot);

endmodule

// ----- rtl/address_window_translator_core.sv -----
// Address window translator.
// request (awt_in_if, sink): one transaction per valid&&ready edge. op selects
//   a table slot write, a virtual-to-physical lookup or a physical-to-virtual
//   lookup. Every transaction, writes included, returns exactly one response.
// response (awt_out_if, source): translated address, what matched (DRAM window
//   or table slot), the slot number and a fault flag when nothing matched.
// cfg_wr_en/cfg_index/cfg_data: writes the DRAM window base and size registers;
//   write only while no transaction is in flight.
// The back end takes each transaction through its compare, select and result
//   steps (ST_CMP, ST_SEL, ST_OUT) before response.valid rises, and it takes
//   the next one from the queue only once the current result is loaded.
// A 2-entry queue sits between the front (accept/classify) and the back end,
//   so request keeps accepting while a result waits in the output register.
// Reset (rst, synchronous): clears the config registers, empties every table
//   slot and the queue, and drops response.valid.
// A stalled receiver holds the response; the back end then stops, the queue
//   fills and request.ready falls once two transactions are queued.
`include "address_window_translator_core_assert.svh"

module address_window_translator_core import awt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  awt_in_if.sink                request,
  awt_out_if.source             response
);

  dram_cfg_t         dram;
  q_head_t           q_head;
  logic [QCNT_W-1:0] q_fill;
  logic              back_pop;

  // DRAM window registers; index 3 is unused and ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      dram <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DRAM_VBASE: dram.vbase <= ADDR_W'(cfg_data);
        CFG_DRAM_PBASE: dram.pbase <= ADDR_W'(cfg_data);
        CFG_DRAM_SIZE:  dram.size  <= ADDR_W'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // Front: accept, classify, queue.
  awt_front u_front (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .pop     (back_pop),
    .head    (q_head),
    .fill    (q_fill)
  );

  // Back: table, range compares, priority select, relocation, output reg.
  awt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .dram     (dram),
    .head     (q_head),
    .pop      (back_pop),
    .response (response)
  );

  // back end never pops an empty queue
  `AWT_ASSERT_IMPL(a_pop_nonempty, back_pop, q_head.valid)
  // queue fill stays within its depth
  `AWT_ASSERT_IMPL(a_fill_bound, 1'b1, q_fill <= QCNT_W'(QUEUE_DEPTH))
  // a fault never comes with a match
  `AWT_ASSERT_IMPL(a_fault_no_match, response.valid && response.fault,
                   response.matched_by == 2'(BY_NONE))
  // a pop with no push drains one entry
  `AWT_ASSERT_NEXT(a_pop_drains, back_pop && !(request.valid && request.ready),
                   q_fill == QCNT_W'($past(q_fill) - 1'b1))

endmodule
